/* design/s98e_pkg.sv */
// ----------------------------------------------------------------------------
// s98e_pkg
// Shared types and constants of the S98 command stream encoder.
// ----------------------------------------------------------------------------
package s98e_pkg;

  localparam int MAX_DEVICES = 32;

  localparam int WAIT_W = 32;
  localparam int TICK_W = 16;
  localparam int SLOT_W = 5;
  localparam int ADDR_W = 9;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 2;
  localparam int VARINT_BITS = 7;

  localparam logic [BYTE_W-1:0] WAIT_ONE_BYTE  = 8'hff;
  localparam logic [BYTE_W-1:0] WAIT_LONG_BYTE = 8'hfe;
  localparam logic [BYTE_W-1:0] END_BYTE       = 8'hfd;
  localparam logic [ADDR_W-1:0] PORT2_ADDR     = 9'h100;

  typedef enum logic [REQ_W-1:0] {
    REQ_WAIT  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_END   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    SEL_WAIT_HDR,
    SEL_VARINT,
    SEL_CMD,
    SEL_ADDR,
    SEL_VALUE,
    SEL_END
  } byte_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WAIT_HDR,
    ST_VARINT,
    ST_CMD,
    ST_ADDR,
    ST_VALUE,
    ST_END
  } state_t;

  typedef struct packed {
    logic      ready;
    logic      take;
    logic      flush;
    logic      shift;
    logic      emit;
    byte_sel_t sel;
    logic      last;
  } ctl_cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      write_ok;
    logic      wait_zero;
    logic      wait_one;
    logic      more;
    logic      slot_free;
  } dp_status_t;

endpackage

/* design/s98e_in_if.sv */
// ----------------------------------------------------------------------------
// s98e_in_if
// Input channel: one register log event per transfer.
// ----------------------------------------------------------------------------
interface s98e_in_if;
  logic                          valid;
  logic                          ready;
  logic [s98e_pkg::REQ_W-1:0]    req_type;
  logic [s98e_pkg::TICK_W-1:0]   wait_ticks;
  logic [s98e_pkg::SLOT_W-1:0]   device_slot;
  logic                          device_enabled;
  logic [s98e_pkg::ADDR_W-1:0]   reg_address;
  logic [s98e_pkg::BYTE_W-1:0]   reg_value;

  modport source (output valid, req_type, wait_ticks, device_slot, device_enabled,
                  reg_address, reg_value, input ready);
  modport sink (input valid, req_type, wait_ticks, device_slot, device_enabled,
                reg_address, reg_value, output ready);
endinterface

/* design/s98e_out_if.sv */
// ----------------------------------------------------------------------------
// s98e_out_if
// Result channel: one S98 command byte per transfer.
// ----------------------------------------------------------------------------
interface s98e_out_if;
  logic                        valid;
  logic                        ready;
  logic [s98e_pkg::BYTE_W-1:0] out_byte;
  logic                        last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

/* design/s98e_datapath.sv */
// ----------------------------------------------------------------------------
// s98e_datapath
// Pending wait accumulator, varint shifter, item latch and output register.
// ----------------------------------------------------------------------------
module s98e_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  s98e_pkg::ctl_cmd_t          cmd,
  output s98e_pkg::dp_status_t        status,
  input  logic [s98e_pkg::REQ_W-1:0]  req_type,
  input  logic [s98e_pkg::TICK_W-1:0] wait_ticks,
  input  logic [s98e_pkg::SLOT_W-1:0] device_slot,
  input  logic                        device_enabled,
  input  logic [s98e_pkg::ADDR_W-1:0] reg_address,
  input  logic [s98e_pkg::BYTE_W-1:0] reg_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [s98e_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);
  import s98e_pkg::*;

  logic [WAIT_W-1:0] pending_r, pending_nxt;
  logic [WAIT_W:0]   wait_sum;
  logic [WAIT_W-1:0] shift_r;
  logic              one_r;
  req_type_t         type_r;
  logic [SLOT_W-1:0] slot_r;
  logic              enabled_r;
  logic [ADDR_W-1:0] addr_r;
  logic [BYTE_W-1:0] value_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r, byte_nxt;
  logic              out_last_r;
  logic              more;

  assign wait_sum = {1'b0, pending_r} + {{(WAIT_W + 1 - TICK_W){1'b0}}, wait_ticks};
  assign more     = |shift_r[WAIT_W-1:VARINT_BITS];

  always_comb begin
    pending_nxt = pending_r;
    if (cmd.take) begin
      pending_nxt = wait_sum[WAIT_W] ? {WAIT_W{1'b1}} : wait_sum[WAIT_W-1:0];
    end else if (cmd.flush) begin
      pending_nxt = '0;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_WAIT_HDR: byte_nxt = one_r ? WAIT_ONE_BYTE : WAIT_LONG_BYTE;
      SEL_VARINT:   byte_nxt = {more, shift_r[VARINT_BITS-1:0]};
      SEL_CMD:      byte_nxt = {{(BYTE_W - SLOT_W - 1){1'b0}}, slot_r,
                                (addr_r >= PORT2_ADDR)};
      SEL_ADDR:     byte_nxt = addr_r[BYTE_W-1:0];
      SEL_VALUE:    byte_nxt = value_r;
      SEL_END:      byte_nxt = END_BYTE;
      default:      byte_nxt = END_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      type_r    <= req_type_t'(req_type);
      slot_r    <= device_slot;
      enabled_r <= device_enabled;
      addr_r    <= reg_address;
      value_r   <= reg_value;
    end
    if (cmd.flush) begin
      shift_r <= pending_r - WAIT_W'(2);
      one_r   <= (pending_r == WAIT_W'(1));
    end else if (cmd.shift) begin
      shift_r <= shift_r >> VARINT_BITS;
    end
    if (cmd.emit) begin
      out_byte_r <= byte_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign status.req_type  = type_r;
  assign status.write_ok  = enabled_r && (int'(slot_r) < MAX_DEVICES);
  assign status.wait_zero = (pending_r == '0);
  assign status.wait_one  = one_r;
  assign status.more      = more;
  assign status.slot_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

/* design/s98e_controller.sv */
// ----------------------------------------------------------------------------
// s98e_controller
// Sequencer that walks one item through wait flush and command bytes.
// ----------------------------------------------------------------------------
module s98e_controller (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  s98e_pkg::dp_status_t  status,
  output s98e_pkg::ctl_cmd_t    cmd
);
  import s98e_pkg::*;

  state_t state_r, state_nxt;
  state_t after_wait;
  logic   is_flush;

  assign is_flush = (status.req_type == REQ_FLUSH);

  always_comb begin
    case (status.req_type)
      REQ_WRITE: after_wait = ST_CMD;
      REQ_END:   after_wait = ST_END;
      default:   after_wait = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_END;
    case (state_r)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.req_type == REQ_WAIT ||
            (status.req_type == REQ_WRITE && !status.write_ok)) begin
          state_nxt = ST_IDLE;
        end else if (status.wait_zero) begin
          state_nxt = after_wait;
        end else begin
          cmd.flush = 1'b1;
          state_nxt = ST_WAIT_HDR;
        end
      end
      ST_WAIT_HDR: begin
        cmd.sel = SEL_WAIT_HDR;
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = status.wait_one && is_flush;
          state_nxt = status.wait_one ? after_wait : ST_VARINT;
        end
      end
      ST_VARINT: begin
        cmd.sel = SEL_VARINT;
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          cmd.last  = !status.more && is_flush;
          state_nxt = status.more ? ST_VARINT : after_wait;
        end
      end
      ST_CMD: begin
        cmd.sel = SEL_CMD;
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.sel = SEL_ADDR;
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_VALUE;
        end
      end
      ST_VALUE: begin
        cmd.sel = SEL_VALUE;
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_END: begin
        cmd.sel = SEL_END;
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/s98_command_stream_encoder.sv */
// ----------------------------------------------------------------------------
// s98_command_stream_encoder
// Turns a timed log of sound-chip register writes into S98 command bytes.
//
// Usage: in_ carries one log event per transfer (wait ticks, register write,
// loop mark or end of stream). out_ carries the resulting command bytes, one
// per transfer, with last_byte set on the final byte of each event. An event
// that produces no bytes (pure wait, dropped write, empty flush) gives no
// transfer on out_.
// The block takes one event at a time, the next only once the final byte
// of the last is emitted. Each event passes an accept and a decode state,
// then emits its bytes (9 bytes worst case: wait prefix, five varint bytes
// and three write bytes). The single output register emits one byte per
// cycle within an event while the receiver is ready. Reset clears the
// pending wait and output valid flag; the block then idles, ready. A stalled
// receiver keeps the byte in the output register and the sequencer waiting.
// ----------------------------------------------------------------------------
module s98_command_stream_encoder (
  input logic        clk,
  input logic        rst_n,
  s98e_in_if.sink    in_,
  s98e_out_if.source out_
);
  import s98e_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign in_.ready = cmd.ready;

  s98e_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_.valid),
    .status   (status),
    .cmd      (cmd)
  );

  s98e_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .req_type       (in_.req_type),
    .wait_ticks     (in_.wait_ticks),
    .device_slot    (in_.device_slot),
    .device_enabled (in_.device_enabled),
    .reg_address    (in_.reg_address),
    .reg_value      (in_.reg_value),
    .out_valid      (out_.valid),
    .out_ready      (out_.ready),
    .out_byte       (out_.out_byte),
    .out_last       (out_.last_byte)
  );

endmodule

/* tb/s98_command_stream_encoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// s98_command_stream_encoder_test
// Drives register log events into the encoder and checks every command byte
// against an in-bench encoder. The run covers field extremes, empty and long
// waits and dropped writes. Random events follow, with random valid/ready
// gaps, one long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module s98_command_stream_encoder_test;
  import s98e_pkg::*;

  localparam int IDLE_PCT     = 34;
  localparam int RANDOM_ITEMS = 307;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 24;

  typedef struct packed {
    req_type_t          kind;
    logic [TICK_W-1:0]  ticks;
    logic [SLOT_W-1:0]  slot;
    logic               enabled;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  value;
    logic               drain;
  } log_event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
  } cmd_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  s98e_in_if  in_if ();
  s98e_out_if out_if ();

  s98_command_stream_encoder u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_   (in_if),
    .out_  (out_if)
  );

  log_event_t       log_q[$];
  cmd_byte_t        cmd_bytes_due[$];
  cmd_byte_t        item_bytes[$];
  logic [WAIT_W-1:0] wait_acc = '0;
  int               sent_cnt = 0;
  int               rx_cnt = 0;
  int               err_cnt = 0;
  logic             hold_off = 1'b0;
  logic             calm;

  assign calm = (sent_cnt >= 150) && (sent_cnt < 230);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_event(req_type_t kind, int ticks, int slot = 0,
                                    bit enabled = 1'b1, int addr = 0, int value = 0,
                                    bit drain = 1'b0);
    log_event_t ev;
    ev.kind    = kind;
    ev.ticks   = ticks[TICK_W-1:0];
    ev.slot    = slot[SLOT_W-1:0];
    ev.enabled = enabled;
    ev.addr    = addr[ADDR_W-1:0];
    ev.value   = value[BYTE_W-1:0];
    ev.drain   = drain;
    log_q = {log_q, ev};
  endfunction

  function automatic void emit_byte(logic [BYTE_W-1:0] b);
    cmd_byte_t cb;
    cb.data = b;
    cb.fin  = 1'b0;
    item_bytes = {item_bytes, cb};
  endfunction

  // Send and clear the pending wait: 0xff for one tick, 0xfe and a varint for more, nothing for none.
  function automatic void flush_wait_bytes();
    logic [WAIT_W-1:0] w;
    w = wait_acc;
    wait_acc = '0;
    if (w == 1) begin
      emit_byte(WAIT_ONE_BYTE);
    end else if (w > 1) begin
      emit_byte(WAIT_LONG_BYTE);
      w = w - 2;
      do begin
        emit_byte({(w >> VARINT_BITS) != 0, w[VARINT_BITS-1:0]});
        w = w >> VARINT_BITS;
      end while (w != 0);
    end
  endfunction

  function automatic void encode_event(log_event_t ev);
    logic [WAIT_W:0] sum;
    item_bytes.delete();
    sum = {1'b0, wait_acc} + {{(WAIT_W + 1 - TICK_W){1'b0}}, ev.ticks};
    wait_acc = sum[WAIT_W] ? '1 : sum[WAIT_W-1:0];
    case (ev.kind)
      REQ_WRITE: begin
        if (ev.enabled && ev.slot < MAX_DEVICES) begin
          flush_wait_bytes();
          emit_byte({2'b00, ev.slot, ev.addr >= PORT2_ADDR});
          emit_byte(ev.addr[BYTE_W-1:0]);
          emit_byte(ev.value);
        end
      end
      REQ_FLUSH: flush_wait_bytes();
      REQ_END: begin
        flush_wait_bytes();
        emit_byte(END_BYTE);
      end
      default: ;
    endcase
    if (item_bytes.size() != 0) begin
      item_bytes[item_bytes.size()-1].fin = 1'b1;
    end
    cmd_bytes_due = {cmd_bytes_due, item_bytes};
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR out transfer %0d: %s", rx_cnt, msg);
    err_cnt++;
  endtask

  // driver: hold while stalled, otherwise offer the next event or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_event(log_q[0]);
        void'(log_q.pop_front());
        sent_cnt++;
      end
      if (in_if.valid && !in_if.ready) begin
        in_if.valid <= 1'b1;
      end else if (log_q.size() != 0 && !(log_q[0].drain && cmd_bytes_due.size() != 0)
                   && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_if.valid          <= 1'b1;
        in_if.req_type       <= log_q[0].kind;
        in_if.wait_ticks     <= log_q[0].ticks;
        in_if.device_slot    <= log_q[0].slot;
        in_if.device_enabled <= log_q[0].enabled;
        in_if.reg_address    <= log_q[0].addr;
        in_if.reg_value      <= log_q[0].value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: check each transfer against the oldest expected byte
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cmd_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_if.out_byte));
        end else begin
          cmd_byte_t want;
          want = cmd_bytes_due.pop_front();
          if (out_if.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_if.out_byte, want.data));
          if (out_if.last_byte !== want.fin)
            report_mismatch($sformatf("last_byte %b, want %b", out_if.last_byte, want.fin));
        end
        rx_cnt++;
      end
      out_if.ready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (sent_cnt >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("s98_command_stream_encoder verification failed");
    $finish;
  end

  initial begin
    int kind_pick;
    int tick_pick;
    int ticks;
    req_type_t kind;

    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.req_type        = REQ_WAIT;
    in_if.wait_ticks      = '0;
    in_if.device_slot     = '0;
    in_if.device_enabled  = 1'b0;
    in_if.reg_address     = '0;
    in_if.reg_value       = '0;
    out_if.ready          = 1'b0;

    add_event(REQ_WRITE, 0, 0, 1'b1, 'h000, 'h00);
    add_event(REQ_WAIT, 1);
    add_event(REQ_WRITE, 0, 31, 1'b1, 'h1ff, 'hff);
    add_event(REQ_FLUSH, 0);
    add_event(REQ_FLUSH, 2);
    add_event(REQ_FLUSH, 129);
    add_event(REQ_FLUSH, 130);
    add_event(REQ_WRITE, 'hffff, 17, 1'b1, 'h100, 'h5a);
    add_event(REQ_WRITE, 7, 3, 1'b0, 'h0ab, 'h12);
    add_event(REQ_WAIT, 0);
    add_event(REQ_WAIT, 'hffff);
    add_event(REQ_FLUSH, 0);
    add_event(REQ_END, 0);
    add_event(REQ_END, 1);
    add_event(REQ_WRITE, 3, 1, 1'b1, 'h0ff, 'ha5);
    add_event(REQ_WRITE, 0, 30, 1'b0, 'h155, 'h55);
    add_event(REQ_END, 0);
    add_event(REQ_FLUSH, 16385);
    add_event(REQ_WRITE, 'h4000, 10, 1'b1, 'h0aa, 'h01);
    add_event(REQ_WAIT, 'h8000, 21, 1'b1, 'h12c, 'h80);
    add_event(REQ_END, 'h7fff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind_pick = $urandom_range(99);
      tick_pick = $urandom_range(99);
      if (kind_pick < 50)      kind = REQ_WRITE;
      else if (kind_pick < 70) kind = REQ_WAIT;
      else if (kind_pick < 85) kind = REQ_FLUSH;
      else                     kind = REQ_END;
      if (tick_pick < 40)      ticks = 0;
      else if (tick_pick < 60) ticks = $urandom_range(3, 1);
      else if (tick_pick < 80) ticks = $urandom_range(300);
      else                     ticks = $urandom_range(16'hffff);
      add_event(kind, ticks, $urandom_range(31), $urandom_range(99) < 85,
                $urandom_range(511), $urandom_range(255), i == 100 || i == 280);
    end

    add_event(REQ_WRITE, 'h1234, 5, 1'b1, 'h1a3, 'h3c);
    add_event(REQ_END, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (log_q.size() == 0);
    wait (cmd_bytes_due.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("s98_command_stream_encoder verification clean");
    end else begin
      $display("s98_command_stream_encoder verification failed");
    end
    $finish;
  end

endmodule
